@@ rtl/pno_pkg.sv @@
// Shared types and constants for the polyline normal offset block.
// Used by pno_unit and polyline_normal_offset; depends on nothing.
`timescale 1ns / 1ps

package pno_pkg;

    // Default geometry of the fixed-point coordinates
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Half width: 24-bit configuration word held in a 25-bit register; reset value is 1 << FRAC_BITS
    localparam int CFG_W = 24;
    localparam int HW_W  = 25;

    // Magnitudes are scaled below 2^MAG_BITS before squaring
    localparam int MAG_BITS = 31;
    localparam int WIDE_W   = 64;

    // Square root and divider step counts and result widths
    localparam int SQ_STEPS = 32;
    localparam int LEN_W    = 32;
    localparam int QB       = 26;
    localparam int NUM_W    = 57;
    localparam int OW       = QB + 1;
    localparam int CNT_W    = 5;

    // Response from the normal unit to the sequencer
    typedef struct packed {
        logic                 done;
        logic                 degen;
        logic signed [OW-1:0] ox;
        logic signed [OW-1:0] oy;
    } pno_resp_t;

endpackage

@@ rtl/pno_unit.sv @@
// Iterative unit for the scaled unit vector of one direction vector.
// One shared multiplier, a square-root step and a divide step under a sequencer.
// Depends on pno_pkg.
`timescale 1ns / 1ps

module pno_unit #(
    parameter int COORD_BITS = pno_pkg::COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [COORD_BITS:0] dx,
    input  logic signed [COORD_BITS:0] dy,
    input  logic [pno_pkg::HW_W-1:0]  hw,
    output pno_pkg::pno_resp_t        resp
);

    localparam int MW = COORD_BITS + 1;
    localparam int WW = pno_pkg::WIDE_W;
    localparam int MB = pno_pkg::MAG_BITS;
    localparam int LW = pno_pkg::LEN_W;
    localparam int QB = pno_pkg::QB;
    localparam int NW = pno_pkg::NUM_W;
    localparam int CW = pno_pkg::CNT_W;
    localparam int OW = pno_pkg::OW;

    localparam logic [3:0] U_IDLE  = 4'd0;
    localparam logic [3:0] U_SHIFT = 4'd1;
    localparam logic [3:0] U_SQX   = 4'd2;
    localparam logic [3:0] U_SQY   = 4'd3;
    localparam logic [3:0] U_SUM   = 4'd4;
    localparam logic [3:0] U_SQRT  = 4'd5;
    localparam logic [3:0] U_MULX  = 4'd6;
    localparam logic [3:0] U_LDX   = 4'd7;
    localparam logic [3:0] U_DIV   = 4'd8;
    localparam logic [3:0] U_MULY  = 4'd9;
    localparam logic [3:0] U_LDY   = 4'd10;
    localparam logic [3:0] U_DONE  = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [MW-1:0]       mx_reg, mx_next, my_reg, my_next;
    logic                sx_reg, sx_next, sy_reg, sy_next;
    logic                degen_reg, degen_next;
    logic                which_reg, which_next;
    logic [WW-1:0]       acc_reg, acc_next;
    logic [WW-1:0]       root_reg, root_next;
    logic [WW-1:0]       bit_reg, bit_next;
    logic [2*MB-1:0]     prod_reg;
    logic [LW-1:0]       len_reg, len_next;
    logic [LW-1:0]       rem_reg, rem_next;
    logic [QB-1:0]       qn_reg, qn_next;
    logic [QB-1:0]       qx_reg, qx_next, qy_reg, qy_next;

    logic [WW-1:0]       mx64, my64, rb;
    logic [MB-1:0]       mul_a, mul_b;
    logic [2*MB-1:0]     prod;
    logic [NW-1:0]       num;
    logic [LW:0]         trial;
    logic                ge;
    logic [MW-1:0]       ax, ay;

    assign mx64 = WW'(mx_reg);
    assign my64 = WW'(my_reg);
    assign ax   = dx[COORD_BITS] ? MW'(-dx) : MW'(dx);
    assign ay   = dy[COORD_BITS] ? MW'(-dy) : MW'(dy);

    // Shared multiplier operand select
    always_comb begin
        case (state_reg)
            U_SQY:  begin mul_a = my64[MB-1:0];  mul_b = my64[MB-1:0]; end
            U_MULX: begin mul_a = MB'(hw);       mul_b = mx64[MB-1:0]; end
            U_MULY: begin mul_a = MB'(hw);       mul_b = my64[MB-1:0]; end
            default: begin mul_a = mx64[MB-1:0]; mul_b = mx64[MB-1:0]; end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Square root step and divide step
    assign rb    = root_reg + bit_reg;
    assign num   = prod_reg[NW-1:0] + NW'(len_reg >> 1);
    assign trial = {rem_reg, qn_reg[QB-1]};
    assign ge    = trial >= {1'b0, len_reg};

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        degen_next = degen_reg;
        which_next = which_reg;
        acc_next   = acc_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        qn_next    = qn_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        unique case (state_reg)
            U_IDLE: begin
                if (start) begin
                    mx_next    = ax;
                    my_next    = ay;
                    sx_next    = dx[COORD_BITS];
                    sy_next    = dy[COORD_BITS];
                    degen_next = (dx == '0) && (dy == '0);
                    if ((dx == '0) && (dy == '0)) begin
                        qx_next    = '0;
                        qy_next    = '0;
                        state_next = U_DONE;
                    end else begin
                        state_next = U_SHIFT;
                    end
                end
            end
            U_SHIFT: begin
                if ((mx64[WW-1:MB] != '0) || (my64[WW-1:MB] != '0)) begin
                    mx_next = mx_reg >> 1;
                    my_next = my_reg >> 1;
                end else begin
                    state_next = U_SQX;
                end
            end
            U_SQX: state_next = U_SQY;
            U_SQY: begin
                acc_next   = WW'(prod_reg);
                state_next = U_SUM;
            end
            U_SUM: begin
                acc_next   = acc_reg + WW'(prod_reg);
                root_next  = '0;
                bit_next   = WW'(1) << (WW - 2);
                cnt_next   = '0;
                state_next = U_SQRT;
            end
            U_SQRT: begin
                if (acc_reg >= rb) begin
                    acc_next  = acc_reg - rb;
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(pno_pkg::SQ_STEPS - 1)) begin
                    state_next = U_MULX;
                end
            end
            U_MULX: begin
                len_next   = (root_reg[LW-1:0] == '0) ? LW'(1) : root_reg[LW-1:0];
                state_next = U_LDX;
            end
            U_LDX, U_LDY: begin
                rem_next   = LW'(num[NW-1:QB]);
                qn_next    = num[QB-1:0];
                cnt_next   = '0;
                which_next = (state_reg == U_LDY);
                state_next = U_DIV;
            end
            U_DIV: begin
                rem_next = ge ? LW'(trial - {1'b0, len_reg}) : LW'(trial);
                qn_next  = {qn_reg[QB-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QB - 1)) begin
                    if (which_reg) begin
                        qy_next    = {qn_reg[QB-2:0], ge};
                        state_next = U_DONE;
                    end else begin
                        qx_next    = {qn_reg[QB-2:0], ge};
                        state_next = U_MULY;
                    end
                end
            end
            U_MULY: state_next = U_LDY;
            U_DONE: state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg   <= cnt_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        degen_reg <= degen_next;
        which_reg <= which_next;
        acc_reg   <= acc_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        len_reg   <= len_next;
        rem_reg   <= rem_next;
        qn_reg    <= qn_next;
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        prod_reg  <= prod;
    end

    // Signed offsets
    assign resp.done  = (state_reg == U_DONE);
    assign resp.degen = degen_reg;
    assign resp.ox    = sx_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
    assign resp.oy    = sy_reg ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});

`ifndef SYNTHESIS
    // Completion is a single-cycle pulse
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        resp.done |=> !resp.done) else $error("done longer than one cycle");
    // A zero direction gives a zero offset
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        resp.done && resp.degen |-> (resp.ox == '0) && (resp.oy == '0))
        else $error("degenerate direction with nonzero offset");
    // Scaling leaves both magnitudes below the squarer range
    a_scaled: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == U_SQX |-> (mx64[WW-1:MB] == '0) && (my64[WW-1:MB] == '0))
        else $error("magnitude not scaled");
`endif

endmodule

@@ rtl/polyline_normal_offset.sv @@
// Top level: point history, result sequencing and output register.
// Depends on pno_pkg and pno_unit.
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Contents
// s_axis    in   tvalid/tready           tdata: point_x, point_y; tlast: last_point
// m_axis    out  tvalid/tready           tdata: left/right edge; tuser: flags; tlast: eol
// cfg       in   cfg_wr_en               cfg_wr_data: half_width
//
// A result with a nonzero direction passes from start to output load through
// scaling, 32 square-root steps, two 26-step divisions and the multiply, load
// and control states. A zero direction goes straight to the done state.
// A point yields zero, one or two results; the input is not ready meanwhile.
// The output register lets the next point enter while a result waits.
// Reset is synchronous, active low; half_width resets to one metre.

module polyline_normal_offset #(
    parameter int COORD_BITS = pno_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = pno_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // point_x, point_y, zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic                           s_axis_tlast,
    // left_x, left_y, right_x, right_y, zero fill
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // degenerate, too_short
    output logic [1:0]                     m_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic                           m_axis_tlast,
    input  logic                           cfg_wr_en,
    input  logic [pno_pkg::CFG_W-1:0]      cfg_wr_data
);

    localparam int CB  = COORD_BITS;
    localparam int OW  = pno_pkg::OW;
    localparam int SW  = ((CB > OW) ? CB : OW) + 2;
    localparam int ODW = ((4*COORD_BITS+7)/8)*8;

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_START = 2'd1;
    localparam logic [1:0] T_RUN   = 2'd2;
    localparam logic [1:0] T_OUT   = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [pno_pkg::HW_W-1:0]  hw_reg;
    logic signed [CB-1:0]      prev_x_reg, prev_y_reg, older_x_reg, older_y_reg;
    logic [1:0]                seen_reg;
    logic signed [CB-1:0]      jcx_reg [2];
    logic signed [CB-1:0]      jcy_reg [2];
    logic signed [CB:0]        jdx_reg [2];
    logic signed [CB:0]        jdy_reg [2];
    logic                      jshort_reg [2];
    logic                      jeol_reg [2];
    logic                      two_reg;
    logic                      sel_reg;
    logic                      out_valid_reg;
    logic [ODW-1:0]            out_data_reg;
    logic [1:0]                out_user_reg;
    logic                      out_last_reg;

    logic signed [CB-1:0]      px, py, ref_x, ref_y;
    logic                      accept, load_out, start;
    pno_pkg::pno_resp_t        resp;
    logic signed [SW-1:0]      cx_w, cy_w, ox_w, oy_w;
    logic [CB-1:0]             lx, ly, rx, ry;

    assign px     = s_axis_tdata[CB-1:0];
    assign py     = s_axis_tdata[2*CB-1:CB];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign start  = (state_reg == T_START);
    assign load_out = (state_reg == T_OUT) && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == T_IDLE);
    assign ref_x  = (seen_reg == 2'd1) ? prev_x_reg : older_x_reg;
    assign ref_y  = (seen_reg == 2'd1) ? prev_y_reg : older_y_reg;

    // Saturate a wide signed sum to the coordinate range
    function automatic logic [CB-1:0] sat_c(input logic signed [SW-1:0] v);
        logic [CB-1:0] r;
        if ((v[SW-1:CB-1] == '0) || (v[SW-1:CB-1] == '1)) begin
            r = v[CB-1:0];
        end else if (v[SW-1]) begin
            r = {1'b1, {(CB-1){1'b0}}};
        end else begin
            r = {1'b0, {(CB-1){1'b1}}};
        end
        return r;
    endfunction

    pno_unit #(.COORD_BITS(COORD_BITS)) u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .dx      (jdx_reg[sel_reg]),
        .dy      (jdy_reg[sel_reg]),
        .hw      (hw_reg),
        .resp    (resp)
    );

    // Edge points of the current job
    assign cx_w = SW'(jcx_reg[sel_reg]);
    assign cy_w = SW'(jcy_reg[sel_reg]);
    assign ox_w = SW'(resp.ox);
    assign oy_w = SW'(resp.oy);
    assign lx   = sat_c(cx_w - oy_w);
    assign ly   = sat_c(cy_w + ox_w);
    assign rx   = sat_c(cx_w + oy_w);
    assign ry   = sat_c(cy_w - ox_w);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (accept && ((seen_reg != 2'd0) || s_axis_tlast)) begin
                    state_next = T_START;
                end
            end
            T_START: state_next = T_RUN;
            T_RUN: begin
                if (resp.done) begin
                    state_next = T_OUT;
                end
            end
            T_OUT: begin
                if (load_out) begin
                    state_next = (!sel_reg && two_reg) ? T_START : T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    // Control state, history and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            hw_reg        <= pno_pkg::HW_W'(1) << FRAC_BITS;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            older_x_reg   <= '0;
            older_y_reg   <= '0;
            seen_reg      <= 2'd0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                hw_reg <= pno_pkg::HW_W'(cfg_wr_data);
            end
            if (accept) begin
                sel_reg <= 1'b0;
                if (seen_reg == 2'd0) begin
                    if (!s_axis_tlast) begin
                        prev_x_reg <= px;
                        prev_y_reg <= py;
                        seen_reg   <= 2'd1;
                    end
                end else if (s_axis_tlast) begin
                    prev_x_reg  <= '0;
                    prev_y_reg  <= '0;
                    older_x_reg <= '0;
                    older_y_reg <= '0;
                    seen_reg    <= 2'd0;
                end else begin
                    older_x_reg <= prev_x_reg;
                    older_y_reg <= prev_y_reg;
                    prev_x_reg  <= px;
                    prev_y_reg  <= py;
                    seen_reg    <= 2'd2;
                end
            end
            if (load_out && !sel_reg && two_reg) begin
                sel_reg <= 1'b1;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Job list for the accepted word
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (seen_reg == 2'd0) begin
                jcx_reg[0]    <= px;
                jcy_reg[0]    <= py;
                jdx_reg[0]    <= '0;
                jdy_reg[0]    <= '0;
                jshort_reg[0] <= 1'b1;
                jeol_reg[0]   <= 1'b1;
                two_reg       <= 1'b0;
            end else begin
                jcx_reg[0]    <= prev_x_reg;
                jcy_reg[0]    <= prev_y_reg;
                jdx_reg[0]    <= {px[CB-1], px} - {ref_x[CB-1], ref_x};
                jdy_reg[0]    <= {py[CB-1], py} - {ref_y[CB-1], ref_y};
                jshort_reg[0] <= 1'b0;
                jeol_reg[0]   <= 1'b0;
                two_reg       <= s_axis_tlast;
            end
            jcx_reg[1]    <= px;
            jcy_reg[1]    <= py;
            jdx_reg[1]    <= {px[CB-1], px} - {prev_x_reg[CB-1], prev_x_reg};
            jdy_reg[1]    <= {py[CB-1], py} - {prev_y_reg[CB-1], prev_y_reg};
            jshort_reg[1] <= 1'b0;
            jeol_reg[1]   <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= ODW'({ry, rx, ly, lx});
            out_user_reg <= {jshort_reg[sel_reg], resp.degen};
            out_last_reg <= jeol_reg[sel_reg];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // The unit only finishes while the sequencer waits for it
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        resp.done |-> state_reg == T_RUN) else $error("unit done outside run");
    // No input word is taken once a job has started
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_axis_tready) else $error("ready during computation");
    // The second job only follows a first one that asked for it
    a_second: assert property (@(posedge aclk) disable iff (!aresetn)
        start && sel_reg |-> two_reg) else $error("second job without request");
`endif

endmodule
